FILE: hw/rtl/pccr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the circle collision resolver.
package pccr_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int FRAC_BITS_DEF     = 16;

    // Configuration register map (index = paddr[2])
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_PASSES = 1'b1;

    localparam logic [30:0] RADIUS_RST = 31'd32768;
    localparam logic [4:0]  PASSES_RST = 5'd1;
    localparam logic [4:0]  PASSES_MAX = 5'd16;

    // Shared multiplier geometry
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [30:0] mass;
    } t_particle;

    // Magnitude of a 33-bit two's complement difference of two 32-bit values
    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] neg_v;
        neg_v = -v;
        return v[32] ? neg_v[31:0] : v[31:0];
    endfunction

    // base +/- (sign * mag), saturated to 32 bits
    function automatic logic [31:0] sat_add(input logic [31:0] base, input logic neg,
                                            input logic [33:0] mag, input logic sub);
        logic signed [39:0] b;
        logic signed [39:0] m;
        logic signed [39:0] s;
        b = $signed({{8{base[31]}}, base});
        m = $signed({6'b0, mag});
        s = (neg ^ sub) ? (b - m) : (b + m);
        if (s > $signed(40'h00_7FFF_FFFF)) begin
            return 32'h7FFF_FFFF;
        end else if (s < $signed(40'hFF_8000_0000)) begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

endpackage

FILE: hw/rtl/pccr_in_if.sv
`timescale 1ns / 1ps
// Input channel: one particle item per handshake.
interface pccr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [30:0] mass;
    logic        last_in;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, mass, last_in, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, mass, last_in, output ready);
endinterface

FILE: hw/rtl/pccr_out_if.sv
`timescale 1ns / 1ps
// Output channel: one resolved particle item per handshake.
interface pccr_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  index;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic        last_out;

    modport source (output valid, index, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    last_out, input ready);
    modport sink   (input valid, index, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    last_out, output ready);
endinterface

FILE: hw/rtl/pccr_store.sv
`timescale 1ns / 1ps
// Particle memory: one write port, two registered read ports.
module pccr_store #(
    parameter int DEPTH = pccr_pkg::MAX_PARTICLES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  pccr_pkg::t_particle i_wdata,
    input  logic [AW-1:0]       i_raddr_a,
    input  logic [AW-1:0]       i_raddr_b,
    output pccr_pkg::t_particle o_rdata_a,
    output pccr_pkg::t_particle o_rdata_b
);

    pccr_pkg::t_particle r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: hw/rtl/pccr_mult.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with registered product.
module pccr_mult (
    input  logic                         i_clk,
    input  logic [pccr_pkg::MUL_A_W-1:0] i_a,
    input  logic [pccr_pkg::MUL_B_W-1:0] i_b,
    output logic [pccr_pkg::MUL_P_W-1:0] o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= pccr_pkg::MUL_P_W'(i_a) * pccr_pkg::MUL_P_W'(i_b);
    end

endmodule

FILE: hw/rtl/pccr_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module pccr_div #(
    parameter int DW = pccr_pkg::FRAC_BITS_DEF + 32,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_dvs;
    logic [DW-1:0]   r_q;
    logic            r_done;

    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;
    logic          ge;

    // one trial subtraction per cycle
    always_comb begin
        rem_sh = {r_rem, r_q[DW-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = !diff[VW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hw/rtl/pccr_sqrt.sv
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one root bit per cycle.
module pccr_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_val;
    logic        r_done;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic [34:0] diff;

    // bring in two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem[31:0], r_val[63:62]};
        trial  = {r_root, 2'b01};
        diff   = {1'b0, rem_sh} - {1'b0, trial};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= i_value;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (!diff[34]) begin
                    r_rem  <= diff[33:0];
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/pairwise_circle_collision_resolve.sv
`timescale 1ns / 1ps
// Pairwise circle collision resolver: loader, pair sequencer and result emitter.
// Loading accepts one item per cycle while idle. Each pass visits n*(n-1)/2 pairs; a pair
// in contact waits on the serial root unit and divider, and an approaching pair on two
// further divisions for the mass ratios (skipped when both masses are zero).
// Results leave one at a time, each held until taken; no item is taken until done.
// Reset clears control, count and configuration; the particle memory is left as is.
module pairwise_circle_collision_resolve #(
    parameter int MAX_PARTICLES = pccr_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = pccr_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pccr_in_if.sink     i_in,
    pccr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int DW = FRAC_BITS + 32;
    localparam int NW = FRAC_BITS + 2;
    localparam int PW = pccr_pkg::MUL_P_W;

    typedef enum logic [5:0] {
        S_IDLE, S_RD, S_LATCH, S_DIFF, S_SQX, S_SQY, S_SQT, S_CMP, S_SQRT,
        S_DIVX, S_DIVY, S_SHX, S_SHY, S_POS, S_VX, S_VY, S_VS, S_VCHK,
        S_K1, S_K2, S_A1, S_A2, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_WRI, S_WRJ, S_ADV, S_ERD, S_ELD, S_EOUT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       r_i;
    logic [AW-1:0]       r_j;
    logic [AW-1:0]       r_e;
    logic [3:0]          r_pass;
    logic [30:0]         r_radius;
    logic [4:0]          r_passes_cfg;
    pccr_pkg::t_particle r_pi;
    pccr_pkg::t_particle r_pj;
    logic [32:0]         r_dx;
    logic [32:0]         r_dy;
    logic [64:0]         r_d2;
    logic [31:0]         r_d;
    logic [NW-1:0]       r_nx;
    logic [NW-1:0]       r_ny;
    logic                r_nx_neg;
    logic                r_ny_neg;
    logic [31:0]         r_half;
    logic [31:0]         r_shx;
    logic [32:0]         r_dvx;
    logic [32:0]         r_dvy;
    logic signed [PW:0]  r_acc;
    logic [32:0]         r_van;
    logic [NW-1:0]       r_k1;
    logic [NW-1:0]       r_k2;
    logic [33:0]         r_a1;
    logic [33:0]         r_a2;
    logic                r_out_valid;
    pccr_pkg::t_particle r_out;
    logic [AW-1:0]       r_out_idx;
    logic                r_out_last;

    // unit hookups
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    pccr_pkg::t_particle          mem_wdata;
    logic [AW-1:0]                mem_raddr_a;
    pccr_pkg::t_particle          mem_rdata_a;
    pccr_pkg::t_particle          mem_rdata_b;
    logic [pccr_pkg::MUL_A_W-1:0] mul_a;
    logic [pccr_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]                prod;
    logic                         sq_start;
    logic                         sq_done;
    logic [31:0]                  sq_root;
    logic                         div_start;
    logic [DW-1:0]                div_dividend;
    logic [31:0]                  div_divisor;
    logic                         div_done;
    logic [DW-1:0]                div_quot;

    logic          accept;
    logic [CW-1:0] cnt_next;
    logic [4:0]    passes;
    logic [31:0]   target;
    logic [31:0]   adx;
    logic [31:0]   ady;
    logic [31:0]   msum;
    logic          contact;
    logic [31:0]   sh_now;
    logic [33:0]   dv_now;
    logic          term_neg;
    logic signed [PW:0] prod_s;
    logic signed [PW:0] term;
    logic          pair_last_j;
    logic          pair_last_i;
    logic          pass_last;

    // ---------------------------------------------------------------------
    // Datapath helpers
    always_comb begin
        accept   = i_in.valid && i_in.ready;
        cnt_next = (r_cnt < CW'(MAX_PARTICLES)) ? r_cnt + CW'(1) : r_cnt;
        passes   = (r_passes_cfg > pccr_pkg::PASSES_MAX) ? pccr_pkg::PASSES_MAX : r_passes_cfg;
        target   = {r_radius, 1'b0};
        adx      = pccr_pkg::mag33(r_dx);
        ady      = pccr_pkg::mag33(r_dy);
        msum     = {1'b0, r_pi.mass} + {1'b0, r_pj.mass};
        contact  = (r_d2 != '0) && (r_d2 <= {1'b0, prod[63:0]});
        sh_now   = prod[FRAC_BITS +: 32];
        dv_now   = prod[FRAC_BITS +: 34];
        term_neg = (r_state == S_VY) ? (r_dvx[32] ^ r_nx_neg) : (r_dvy[32] ^ r_ny_neg);
        prod_s   = $signed({1'b0, prod});
        term     = term_neg ? -prod_s : prod_s;
        pair_last_j = (CW'(r_j) == r_cnt - CW'(1));
        pair_last_i = (CW'(r_i) == r_cnt - CW'(2));
        pass_last   = ({1'b0, r_pass} == passes - 5'd1);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin mul_a = 34'(adx);    mul_b = adx;         end
            S_SQY: begin mul_a = 34'(ady);    mul_b = ady;         end
            S_SQT: begin mul_a = 34'(target); mul_b = target;      end
            S_SHX: begin mul_a = 34'(r_half); mul_b = 32'(r_nx);   end
            S_SHY: begin mul_a = 34'(r_half); mul_b = 32'(r_ny);   end
            S_VX:  begin mul_a = 34'(pccr_pkg::mag33(r_dvx)); mul_b = 32'(r_nx); end
            S_VY:  begin mul_a = 34'(pccr_pkg::mag33(r_dvy)); mul_b = 32'(r_ny); end
            S_A1:  begin mul_a = 34'(r_van);  mul_b = 32'(r_k1);   end
            S_A2:  begin mul_a = 34'(r_van);  mul_b = 32'(r_k2);   end
            S_M1:  begin mul_a = r_a1;        mul_b = 32'(r_nx);   end
            S_M2:  begin mul_a = r_a1;        mul_b = 32'(r_ny);   end
            S_M3:  begin mul_a = r_a2;        mul_b = 32'(r_nx);   end
            S_M4:  begin mul_a = r_a2;        mul_b = 32'(r_ny);   end
            default: begin mul_a = '0;        mul_b = '0;          end
        endcase
    end

    // divider and root launches
    always_comb begin
        sq_start     = (r_state == S_CMP) && contact;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_SQRT: begin
                div_start    = sq_done;
                div_dividend = {adx, FRAC_BITS'(0)};
                div_divisor  = sq_root;
            end
            S_DIVX: begin
                div_start    = div_done;
                div_dividend = {ady, FRAC_BITS'(0)};
                div_divisor  = r_d;
            end
            S_VCHK: begin
                div_start    = !r_acc[PW] && (msum != '0);
                div_dividend = {r_pj.mass, (FRAC_BITS + 1)'(0)};
                div_divisor  = msum;
            end
            S_K1: begin
                div_start    = div_done;
                div_dividend = {r_pi.mass, (FRAC_BITS + 1)'(0)};
                div_divisor  = msum;
            end
            default: begin
                div_start    = 1'b0;
            end
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_pi;
        if (accept) begin
            mem_we    = r_cnt < CW'(MAX_PARTICLES);
            mem_waddr = r_cnt[AW-1:0];
            mem_wdata = '{px: i_in.pos_x, py: i_in.pos_y, vx: i_in.vel_x, vy: i_in.vel_y,
                          mass: i_in.mass};
        end else if (r_state == S_WRI) begin
            mem_we = 1'b1;
        end else if (r_state == S_WRJ) begin
            mem_we    = 1'b1;
            mem_waddr = r_j;
            mem_wdata = r_pj;
        end
        mem_raddr_a = (r_state == S_ERD) ? r_e : r_i;
    end

    // ---------------------------------------------------------------------
    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_radius     <= pccr_pkg::RADIUS_RST;
            r_passes_cfg <= pccr_pkg::PASSES_RST;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                unique case (paddr[2])
                    pccr_pkg::REG_RADIUS: r_radius     <= pwdata[30:0];
                    pccr_pkg::REG_PASSES: r_passes_cfg <= pwdata[4:0];
                    default: r_radius <= r_radius;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt <= cnt_next;
                        if (i_in.last_in) begin
                            r_i    <= '0;
                            r_j    <= AW'(1);
                            r_pass <= '0;
                            r_e    <= '0;
                            if (cnt_next >= CW'(2) && passes != 5'd0) begin
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_ERD;
                            end
                        end
                    end
                end
                S_RD:    r_state <= S_LATCH;
                S_LATCH: begin
                    r_pi    <= mem_rdata_a;
                    r_pj    <= mem_rdata_b;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx    <= {r_pj.px[31], r_pj.px} - {r_pi.px[31], r_pi.px};
                    r_dy    <= {r_pj.py[31], r_pj.py} - {r_pi.py[31], r_pi.py};
                    r_state <= S_SQX;
                end
                S_SQX:   r_state <= S_SQY;
                S_SQY: begin
                    r_d2    <= {1'b0, prod[63:0]};
                    r_state <= S_SQT;
                end
                S_SQT: begin
                    r_d2    <= r_d2 + {1'b0, prod[63:0]};
                    r_state <= S_CMP;
                end
                S_CMP:   r_state <= contact ? S_SQRT : S_ADV;
                S_SQRT: begin
                    if (sq_done) begin
                        r_d     <= sq_root;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_nx     <= div_quot[NW-1:0];
                        r_nx_neg <= r_dx[32];
                        r_state  <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_ny     <= div_quot[NW-1:0];
                        r_ny_neg <= r_dy[32];
                        r_half   <= (target - r_d) >> 1;
                        r_state  <= S_SHX;
                    end
                end
                S_SHX:   r_state <= S_SHY;
                S_SHY: begin
                    r_shx   <= sh_now;
                    r_state <= S_POS;
                end
                S_POS: begin
                    // push apart by half the overlap each
                    r_pi.px <= pccr_pkg::sat_add(r_pi.px, r_nx_neg, 34'(r_shx), 1'b1);
                    r_pi.py <= pccr_pkg::sat_add(r_pi.py, r_ny_neg, 34'(sh_now), 1'b1);
                    r_pj.px <= pccr_pkg::sat_add(r_pj.px, r_nx_neg, 34'(r_shx), 1'b0);
                    r_pj.py <= pccr_pkg::sat_add(r_pj.py, r_ny_neg, 34'(sh_now), 1'b0);
                    r_dvx   <= {r_pi.vx[31], r_pi.vx} - {r_pj.vx[31], r_pj.vx};
                    r_dvy   <= {r_pi.vy[31], r_pi.vy} - {r_pj.vy[31], r_pj.vy};
                    r_state <= S_VX;
                end
                S_VX:    r_state <= S_VY;
                S_VY: begin
                    r_acc   <= term;
                    r_state <= S_VS;
                end
                S_VS: begin
                    r_acc   <= r_acc + term;
                    r_state <= S_VCHK;
                end
                S_VCHK: begin
                    // separating pair: no impulse
                    r_van <= r_acc[FRAC_BITS +: 33];
                    if (r_acc[PW]) begin
                        r_state <= S_WRI;
                    end else if (msum == '0) begin
                        r_k1    <= NW'(1) << FRAC_BITS;
                        r_k2    <= NW'(1) << FRAC_BITS;
                        r_state <= S_A1;
                    end else begin
                        r_state <= S_K1;
                    end
                end
                S_K1: begin
                    if (div_done) begin
                        r_k1    <= div_quot[NW-1:0];
                        r_state <= S_K2;
                    end
                end
                S_K2: begin
                    if (div_done) begin
                        r_k2    <= div_quot[NW-1:0];
                        r_state <= S_A1;
                    end
                end
                S_A1:    r_state <= S_A2;
                S_A2: begin
                    r_a1    <= dv_now;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_a2    <= dv_now;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_pi.vx <= pccr_pkg::sat_add(r_pi.vx, r_nx_neg, dv_now, 1'b1);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_pi.vy <= pccr_pkg::sat_add(r_pi.vy, r_ny_neg, dv_now, 1'b1);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_pj.vx <= pccr_pkg::sat_add(r_pj.vx, r_nx_neg, dv_now, 1'b0);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_pj.vy <= pccr_pkg::sat_add(r_pj.vy, r_ny_neg, dv_now, 1'b0);
                    r_state <= S_WRI;
                end
                S_WRI:   r_state <= S_WRJ;
                S_WRJ:   r_state <= S_ADV;
                S_ADV: begin
                    // next pair in (i, j) order, then next pass
                    if (!pair_last_j) begin
                        r_j     <= r_j + AW'(1);
                        r_state <= S_RD;
                    end else if (!pair_last_i) begin
                        r_i     <= r_i + AW'(1);
                        r_j     <= r_i + AW'(2);
                        r_state <= S_RD;
                    end else if (!pass_last) begin
                        r_pass  <= r_pass + 4'd1;
                        r_i     <= '0;
                        r_j     <= AW'(1);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_ERD;
                    end
                end
                S_ERD:   r_state <= S_ELD;
                S_ELD: begin
                    r_out       <= mem_rdata_a;
                    r_out_idx   <= r_e;
                    r_out_last  <= (CW'(r_e) == r_cnt - CW'(1));
                    r_out_valid <= 1'b1;
                    r_state     <= S_EOUT;
                end
                S_EOUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_e     <= r_e + AW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Units
    pccr_store #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (r_j),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    pccr_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pccr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_d2[63:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    pccr_div #(.DW(DW), .VW(32)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------------------------------------------------------------
    // Ports
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.index     = 6'(r_out_idx);
    assign o_out.new_pos_x = r_out.px;
    assign o_out.new_pos_y = r_out.py;
    assign o_out.new_vel_x = r_out.vx;
    assign o_out.new_vel_y = r_out.vy;
    assign o_out.last_out  = r_out_last;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == pccr_pkg::REG_RADIUS) ? {1'b0, r_radius}
                                                                : {27'b0, r_passes_cfg};

    // ---------------------------------------------------------------------
    // Checks
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("root unit finished outside its wait state");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVX || r_state == S_DIVY || r_state == S_K1
                      || r_state == S_K2))
        else $error("divider finished outside a wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_PARTICLES))
        else $error("particle count above capacity");

endmodule
